[sv/indexed_list_insert_erase_assert.svh]
// Assertion macros for the indexed list block.
`ifndef INDEXED_LIST_INSERT_ERASE_ASSERT_SVH
`define INDEXED_LIST_INSERT_ERASE_ASSERT_SVH

`ifndef SYNTHESIS
`define ILIE_ASSERT_ALWAYS(lbl, clock, rstn, expr) \
    lbl: assert property (@(posedge clock) disable iff (!rstn) (expr)) \
        else $error("invariant violated");
`define ILIE_ASSERT_IMP(lbl, clock, rstn, ante, cons) \
    lbl: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication violated");
`define ILIE_ASSERT_NEXT(lbl, clock, rstn, ante, cons) \
    lbl: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define ILIE_ASSERT_ALWAYS(lbl, clock, rstn, expr)
`define ILIE_ASSERT_IMP(lbl, clock, rstn, ante, cons)
`define ILIE_ASSERT_NEXT(lbl, clock, rstn, ante, cons)
`endif

`endif

[sv/ilie_pkg.sv]
`timescale 1ns / 1ps
package ilie_pkg;

    localparam int CAPACITY   = 64;
    localparam int ELEM_WIDTH = 32;

    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 3'd1;
    localparam logic [OP_W-1:0] OP_READ   = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_FILL   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BOUNDS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] item_value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   read_value;
        logic [COUNT_W-1:0]  count;
    } rsp_t;

endpackage

[sv/indexed_list_insert_erase.sv]
`timescale 1ns / 1ps
// Clear, unused ops, rejected requests and erase of the last element go straight to
// S_RESP; read passes through S_READ; insert at index p shifts entries up from the tail
// (S_UP), then writes (S_PUT), appending when p >= length; erase at index p shifts
// entries down (S_DOWN); fill writes every entry (S_FILL). One transaction at a time:
// req_ready rises with rsp_valid; a result still held at rsp stalls the next one's result.
// Reset clears the length and control state; element memory is not cleared.
`include "indexed_list_insert_erase_assert.svh"

module indexed_list_insert_erase #(
    parameter int CAPACITY   = ilie_pkg::CAPACITY,
    parameter int ELEM_WIDTH = ilie_pkg::ELEM_WIDTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ilie_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ilie_pkg::rsp_t rsp
);

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > ilie_pkg::POS_W) ? CNT_W : ilie_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_PUT,
        S_DOWN,
        S_READ,
        S_FILL,
        S_RESP
    } state_t;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [CNT_W-1:0]                src_reg, src_next;
    logic [CNT_W-1:0]                pos_reg, pos_next;
    logic [ELEM_WIDTH-1:0]           val_reg, val_next;
    logic [ilie_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [ilie_pkg::DATA_W-1:0]     rd_reg, rd_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    ilie_pkg::rsp_t                  rsp_reg, rsp_next;

    // element memory
    logic [ELEM_WIDTH-1:0] mem [CAPACITY];
    logic [ELEM_WIDTH-1:0] rdata_reg;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [ELEM_WIDTH-1:0] wdata;
    logic                  rd_en;
    logic [AW-1:0]         raddr;

    logic [CMP_W-1:0] pos_cmp;
    logic [CMP_W-1:0] cnt_cmp;
    logic [CNT_W-1:0] last_idx;
    logic             rsp_free;

    assign pos_cmp   = CMP_W'(req.position);
    assign cnt_cmp   = CMP_W'(count_reg);
    assign last_idx  = count_reg - CNT_W'(1);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        src_next       = src_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        status_next    = status_reg;
        rd_next        = rd_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = val_reg;
        rd_en          = 1'b0;
        raddr          = '0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    val_next    = ELEM_WIDTH'(req.item_value);
                    status_next = ilie_pkg::ST_OK;
                    rd_next     = '0;
                    state_next  = S_RESP;
                    unique if (req.op == ilie_pkg::OP_INSERT)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = ilie_pkg::ST_FULL;
                        end
                        else
                        begin
                            pos_next = (pos_cmp > cnt_cmp) ? count_reg : CNT_W'(req.position);
                            if (pos_cmp >= cnt_cmp)
                            begin
                                state_next = S_PUT;
                            end
                            else
                            begin
                                // walk from the tail down to the insert index
                                rd_en      = 1'b1;
                                raddr      = AW'(last_idx);
                                src_next   = last_idx;
                                state_next = S_UP;
                            end
                        end
                    end
                    else if (req.op == ilie_pkg::OP_ERASE)
                    begin
                        if (pos_cmp >= cnt_cmp)
                        begin
                            status_next = ilie_pkg::ST_BOUNDS;
                        end
                        else if (CNT_W'(req.position) == last_idx)
                        begin
                            count_next = last_idx;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            raddr      = AW'(CNT_W'(req.position) + CNT_W'(1));
                            src_next   = CNT_W'(req.position) + CNT_W'(1);
                            state_next = S_DOWN;
                        end
                    end
                    else if (req.op == ilie_pkg::OP_READ)
                    begin
                        if (pos_cmp >= cnt_cmp)
                        begin
                            status_next = ilie_pkg::ST_BOUNDS;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            raddr      = AW'(req.position);
                            state_next = S_READ;
                        end
                    end
                    else if (req.op == ilie_pkg::OP_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else if (req.op == ilie_pkg::OP_FILL)
                    begin
                        src_next   = '0;
                        state_next = S_FILL;
                    end
                    else
                    begin
                        // unused op codes leave the list unchanged
                    end
                end
            end

            S_UP:
            begin
                we    = 1'b1;
                waddr = AW'(src_reg + CNT_W'(1));
                wdata = rdata_reg;
                if (src_reg == pos_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    rd_en    = 1'b1;
                    raddr    = AW'(src_reg - CNT_W'(1));
                    src_next = src_reg - CNT_W'(1);
                end
            end

            S_PUT:
            begin
                we         = 1'b1;
                waddr      = AW'(pos_reg);
                count_next = count_reg + CNT_W'(1);
                state_next = S_RESP;
            end

            S_DOWN:
            begin
                we    = 1'b1;
                waddr = AW'(src_reg - CNT_W'(1));
                wdata = rdata_reg;
                if (src_reg == last_idx)
                begin
                    count_next = last_idx;
                    state_next = S_RESP;
                end
                else
                begin
                    rd_en    = 1'b1;
                    raddr    = AW'(src_reg + CNT_W'(1));
                    src_next = src_reg + CNT_W'(1);
                end
            end

            S_READ:
            begin
                rd_next    = ilie_pkg::DATA_W'(rdata_reg);
                state_next = S_RESP;
            end

            S_FILL:
            begin
                we    = 1'b1;
                waddr = AW'(src_reg);
                if (src_reg == CNT_W'(CAPACITY - 1))
                begin
                    count_next = CNT_W'(CAPACITY);
                    state_next = S_RESP;
                end
                else
                begin
                    src_next = src_reg + CNT_W'(1);
                end
            end

            S_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.status     = status_reg;
                    rsp_next.read_value = rd_reg;
                    rsp_next.count      = ilie_pkg::COUNT_W'(count_reg);
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            src_reg       <= '0;
            pos_reg       <= '0;
            val_reg       <= '0;
            status_reg    <= ilie_pkg::ST_OK;
            rd_reg        <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            src_reg       <= src_next;
            pos_reg       <= pos_next;
            val_reg       <= val_next;
            status_reg    <= status_next;
            rd_reg        <= rd_next;
            rsp_reg       <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    `ILIE_ASSERT_ALWAYS(a_count_in_range, clk, rst_n, count_reg <= CNT_W'(CAPACITY))
    `ILIE_ASSERT_IMP(a_no_rw_collision, clk, rst_n, we && rd_en, waddr != raddr)
    `ILIE_ASSERT_NEXT(a_leave_idle, clk, rst_n, req_valid && req_ready, state_reg != S_IDLE)
    `ILIE_ASSERT_IMP(a_stall, clk, rst_n, state_reg == S_RESP && !rsp_free, state_next == S_RESP)

endmodule
